### rtl/ffac_pkg.sv
package ffac_pkg;

  localparam int STATUS_W = 2;
  localparam int START_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int OWNER_W  = 8;
  localparam int SIZE_W   = 7;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_address;
    logic [COUNT_W-1:0]  location_count;
  } res_t;

endpackage

### rtl/ffac_map_ram.sv
module ffac_map_ram
  import ffac_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [OWNER_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [OWNER_W-1:0] rdata
);

  logic [OWNER_W-1:0] mem [DEPTH];
  logic [OWNER_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ffac_ctrl.sv
module ffac_ctrl
  import ffac_pkg::*;
#(
  parameter int LOCATIONS = 64,
  parameter int AW        = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_func,
  input  logic [OWNER_W-1:0] in_owner_id,
  input  logic [SIZE_W-1:0]  in_block_size,
  output logic               busy,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [OWNER_W-1:0] mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [OWNER_W-1:0] mem_rdata,
  output res_t               res
);

  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(LOCATIONS - 1);
  localparam logic [CW-1:0] FULL = CW'(LOCATIONS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_PACK  = 3'd4;
  localparam logic [2:0] S_ZERO  = 3'd5;

  logic [2:0]         state_r,   state_nxt;
  logic [OWNER_W-1:0] owner_r,   owner_nxt;
  logic [SIZE_W-1:0]  size_r,    size_nxt;
  logic [SIZE_W-1:0]  run_r,     run_nxt;
  logic [SIZE_W-1:0]  left_r,    left_nxt;
  logic [CW-1:0]      rd_cnt_r,  rd_cnt_nxt;
  logic [CW-1:0]      wr_cnt_r,  wr_cnt_nxt;
  logic [CW-1:0]      free_r,    free_nxt;
  logic [AW-1:0]      chk_r,     chk_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]      base_r,    base_nxt;
  res_t               res_r,     res_nxt;

  always_comb begin
    state_nxt   = state_r;
    owner_nxt   = owner_r;
    size_nxt    = size_r;
    run_nxt     = run_r;
    left_nxt    = left_r;
    rd_cnt_nxt  = rd_cnt_r;
    wr_cnt_nxt  = wr_cnt_r;
    free_nxt    = free_r;
    chk_nxt     = chk_r;
    chk_vld_nxt = 1'b0;
    base_nxt    = base_r;
    res_nxt     = '0;
    mem_we      = 1'b0;
    mem_waddr   = wr_cnt_r[AW-1:0];
    mem_wdata   = '0;
    mem_raddr   = rd_cnt_r[AW-1:0];

    if ((state_r == S_SCAN || state_r == S_PACK) && rd_cnt_r != FULL) begin
      rd_cnt_nxt  = rd_cnt_r + CW'(1);
      chk_nxt     = rd_cnt_r[AW-1:0];
      chk_vld_nxt = 1'b1;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we     = 1'b1;
        wr_cnt_nxt = wr_cnt_r + CW'(1);
        if (wr_cnt_r[AW-1:0] == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          owner_nxt  = in_owner_id;
          size_nxt   = in_block_size;
          run_nxt    = '0;
          rd_cnt_nxt = '0;
          wr_cnt_nxt = '0;
          free_nxt   = '0;
          if (in_owner_id == '0 || (in_func == FUNC_ALLOC && in_block_size == '0)) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_INVALID;
          end else if (in_func == FUNC_ALLOC && 32'(in_block_size) > LOCATIONS) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_NOFIT;
          end else if (in_func == FUNC_ALLOC) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_PACK;
          end
        end
      end
      S_SCAN: begin
        if (chk_vld_r) begin
          if (mem_rdata == '0) begin
            run_nxt = run_r + SIZE_W'(1);
            if (run_nxt == size_r) begin
              base_nxt    = AW'(32'(chk_r) + 32'd1 - 32'(size_r));
              wr_cnt_nxt  = CW'(32'(chk_r) + 32'd1 - 32'(size_r));
              left_nxt    = size_r;
              chk_vld_nxt = 1'b0;
              state_nxt   = S_FILL;
            end
          end else begin
            run_nxt = '0;
          end
          if (state_nxt == S_SCAN && chk_r == LAST) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_NOFIT;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_FILL: begin
        mem_we     = 1'b1;
        mem_wdata  = owner_r;
        wr_cnt_nxt = wr_cnt_r + CW'(1);
        left_nxt   = left_r - SIZE_W'(1);
        if (left_r == SIZE_W'(1)) begin
          res_nxt.valid          = 1'b1;
          res_nxt.status         = ST_DONE;
          res_nxt.start_address  = START_W'(base_r);
          res_nxt.location_count = COUNT_W'(size_r);
          state_nxt              = S_IDLE;
        end
      end
      S_PACK: begin
        if (chk_vld_r) begin
          if (mem_rdata == owner_r) begin
            free_nxt = free_r + CW'(1);
          end else if (mem_rdata != '0) begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata;
            wr_cnt_nxt = wr_cnt_r + CW'(1);
          end
          if (chk_r == LAST) begin
            chk_vld_nxt = 1'b0;
            if (wr_cnt_nxt == FULL) begin
              res_nxt.valid          = 1'b1;
              res_nxt.status         = ST_DONE;
              res_nxt.location_count = COUNT_W'(free_nxt);
              state_nxt              = S_IDLE;
            end else begin
              state_nxt = S_ZERO;
            end
          end
        end
      end
      S_ZERO: begin
        mem_we     = 1'b1;
        wr_cnt_nxt = wr_cnt_r + CW'(1);
        if (wr_cnt_r[AW-1:0] == LAST) begin
          res_nxt.valid          = 1'b1;
          res_nxt.status         = ST_DONE;
          res_nxt.location_count = COUNT_W'(free_r);
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      wr_cnt_r  <= '0;
      rd_cnt_r  <= '0;
      chk_vld_r <= 1'b0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      wr_cnt_r  <= wr_cnt_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
    size_r  <= size_nxt;
    run_r   <= run_nxt;
    left_r  <= left_nxt;
    free_r  <= free_nxt;
    chk_r   <= chk_nxt;
    base_r  <= base_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

  a_res_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.valid |-> state_r == S_IDLE)
    else $error("result strobe outside the idle state");

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == S_IDLE) |=> (res_r.valid || state_r != S_IDLE))
    else $error("accepted transaction neither answered nor in progress");

  a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PACK && chk_vld_r) |-> wr_cnt_r <= {1'b0, chk_r})
    else $error("compaction write pointer overtook the read pointer");

  a_fill_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> left_r != '0)
    else $error("allocation fill with nothing left to write");

endmodule

### rtl/first_fit_allocator_compaction_core.sv
// An allocate scans the map for the first free run of block_size locations, then writes
// the owner into it; a release compacts the map and then clears the freed locations at
// the top. Invalid and oversized requests answer next cycle. One transaction at a time;
// the map memory has one read and one write port.
// After reset the map is cleared to zero with busy held high.
// The result strobe lasts one cycle and the receiver cannot stall it.
module first_fit_allocator_compaction_core
  import ffac_pkg::*;
#(
  parameter int LOCATIONS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [OWNER_W-1:0]  in_owner_id,
  input  logic [SIZE_W-1:0]   in_block_size,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [START_W-1:0]  out_start_address,
  output logic [COUNT_W-1:0]  out_location_count
);

  localparam int AW = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [OWNER_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [OWNER_W-1:0] mem_rdata;
  res_t               res;

  ffac_map_ram #(
    .DEPTH (LOCATIONS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffac_ctrl #(
    .LOCATIONS (LOCATIONS),
    .AW        (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_func       (in_func),
    .in_owner_id   (in_owner_id),
    .in_block_size (in_block_size),
    .busy          (busy),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .res           (res)
  );

  assign out_valid          = res.valid;
  assign out_status         = res.status;
  assign out_start_address  = res.start_address;
  assign out_location_count = res.location_count;

endmodule
